>>> sv/zttc_pkg.sv
// shared constants and helper functions for the zero trim caseless compare block
`timescale 1ns / 1ps

package zttc_pkg;

    // byte codes used in normalization
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] ZERO_CHAR   = 8'h30;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // result order codes
    localparam logic [1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [1:0] ORDER_LESS    = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    // register index of the pad mode register
    localparam logic REG_PAD_SPACE = 1'b0;

    // ascii uppercase of one byte
    function automatic logic [7:0] up_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // byte dropped while no significant byte has been seen
    function automatic logic is_lead_skip(input logic [7:0] c);
        return (c == ZERO_CHAR) || (c == SPACE_CHAR);
    endfunction

endpackage

>>> sv/zttc_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module zttc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> sv/zero_trim_caseless_compare_core.sv
// top level of the zero trim caseless string comparator
`timescale 1ns / 1ps

// Compares two byte strings after trimming leading '0' and space bytes, and
// trailing spaces when pad_space is set, ignoring ascii letter case.
// Input stream s_*: tuser selects the string (0 first, 1 second), tdata holds
// the byte and a no-byte flag, tlast on the second string ends the pair.
// Bytes of the first string go into a MAX_LEN byte buffer ram; each byte of
// the second string reads the matching entry and compares it in stage s1.
// Output stream m_*: one item per pair, loaded via the compare stage into the
// output register once the item ending the second string is accepted; it
// holds the order code and an overflow flag for strings longer than MAX_LEN
// after leading trim. Throughput is one input item per cycle while no result
// is blocked at the output, set by the single buffer port pair (one write or
// one read per item). After a result item all pair state is cleared and the
// next pair may follow in the next cycle. Reset clears all control state and
// pad_space; buffer contents are not cleared and need no clearing pass. When
// the receiver stalls, one result waits in the output register; s_tready
// drops only while a second result is ready behind it.
// APB port: register 0 (byte address 0) is pad_space in bit 0.
module zero_trim_caseless_compare_core
    import zttc_pkg::*;
#(
    parameter int MAX_LEN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] char_byte, [8] no_byte, [15:9] zero
    input  logic        s_tuser,    // [0] mode
    input  logic        s_tlast,    // last_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [1:0] order, [2] overflow, [7:3] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    // configuration register
    logic pad_space_reg;

    // pair state updated at accept
    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] first_sig_reg, first_sig_next;
    logic             first_started_reg, first_started_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic [CNT_W-1:0] second_sig_reg, second_sig_next;
    logic             second_started_reg, second_started_next;
    logic             overflow_reg, overflow_next;

    // compare stage
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_res_reg, s1_res_next;
    logic             s1_cmp_reg, s1_cmp_next;
    logic [7:0]       s1_byte_reg;
    logic [CNT_W-1:0] s1_index_reg;
    logic [CNT_W-1:0] s1_first_sig_reg, s1_second_sig_reg;
    logic             s1_ovf_reg;

    // tentative first difference
    logic             diff_found_reg, diff_found_next;
    logic [CNT_W-1:0] diff_index_reg, diff_index_next;
    logic             diff_less_reg, diff_less_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_order_reg, out_order_next;
    logic             out_ovf_reg, out_ovf_next;

    // ram ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    logic       accept, s1_move, cmp_hit;
    logic       in_mode, in_none, in_last;
    logic [7:0] in_byte, a_up, b_up;
    logic       keep_first, keep_second;

    assign in_byte = s_tdata[7:0];
    assign in_none = s_tdata[8];
    assign in_mode = s_tuser;
    assign in_last = s_tlast;

    // apb port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAD_SPACE) ? {31'd0, pad_space_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_space_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_PAD_SPACE)
        begin
            pad_space_reg <= pwdata[0];
        end
    end

    // handshakes
    assign s1_move  = s1_valid_reg && (!s1_res_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    // bytes kept after leading trim
    assign keep_first  = accept && !in_mode && !in_none
                         && (first_started_reg || !is_lead_skip(in_byte));
    assign keep_second = accept && in_mode && !in_none
                         && (second_started_reg || !is_lead_skip(in_byte));

    // buffer access: first string writes, second string reads
    assign ram_we    = keep_first && (first_count_reg < MAX_CNT);
    assign ram_waddr = first_count_reg[ADDR_W-1:0];
    assign ram_re    = keep_second && (second_count_reg < MAX_CNT);
    assign ram_raddr = second_count_reg[ADDR_W-1:0];

    zttc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_first_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // count and length update at accept
    always_comb
    begin
        first_count_next    = first_count_reg;
        first_sig_next      = first_sig_reg;
        first_started_next  = first_started_reg;
        second_count_next   = second_count_reg;
        second_sig_next     = second_sig_reg;
        second_started_next = second_started_reg;
        overflow_next       = overflow_reg;
        if (keep_first)
        begin
            first_started_next = 1'b1;
            if (first_count_reg >= MAX_CNT)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                first_count_next = first_count_reg + 1'b1;
                if (!pad_space_reg || in_byte != SPACE_CHAR)
                begin
                    first_sig_next = first_count_reg + 1'b1;
                end
            end
        end
        if (keep_second)
        begin
            second_started_next = 1'b1;
            if (second_count_reg >= MAX_CNT)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                second_count_next = second_count_reg + 1'b1;
                if (!pad_space_reg || in_byte != SPACE_CHAR)
                begin
                    second_sig_next = second_count_reg + 1'b1;
                end
            end
        end
    end

    // compare stage control
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_move;
        s1_res_next   = s1_res_reg;
        s1_cmp_next   = s1_cmp_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_res_next   = in_mode && in_last;
            s1_cmp_next   = ram_re && (second_count_reg < first_sig_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg    <= '0;
            first_sig_reg      <= '0;
            first_started_reg  <= 1'b0;
            second_count_reg   <= '0;
            second_sig_reg     <= '0;
            second_started_reg <= 1'b0;
            overflow_reg       <= 1'b0;
            s1_valid_reg       <= 1'b0;
            s1_res_reg         <= 1'b0;
            s1_cmp_reg         <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_res_reg   <= s1_res_next;
            s1_cmp_reg   <= s1_cmp_next;
            if (accept && in_mode && in_last)
            begin
                // pair ends: counters restart for the next pair
                first_count_reg    <= '0;
                first_sig_reg      <= '0;
                first_started_reg  <= 1'b0;
                second_count_reg   <= '0;
                second_sig_reg     <= '0;
                second_started_reg <= 1'b0;
                overflow_reg       <= 1'b0;
            end
            else
            begin
                first_count_reg    <= first_count_next;
                first_sig_reg      <= first_sig_next;
                first_started_reg  <= first_started_next;
                second_count_reg   <= second_count_next;
                second_sig_reg     <= second_sig_next;
                second_started_reg <= second_started_next;
                overflow_reg       <= overflow_next;
            end
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg       <= in_byte;
            s1_index_reg      <= second_count_reg;
            s1_first_sig_reg  <= first_sig_next;
            s1_second_sig_reg <= second_sig_next;
            s1_ovf_reg        <= overflow_next;
        end
    end

    // difference tracking and result
    assign a_up    = up_ascii(ram_rdata);
    assign b_up    = up_ascii(s1_byte_reg);
    assign cmp_hit = s1_cmp_reg && !diff_found_reg && (a_up != b_up);

    always_comb
    begin
        diff_found_next = diff_found_reg;
        diff_index_next = diff_index_reg;
        diff_less_next  = diff_less_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_order_next  = out_order_reg;
        out_ovf_next    = out_ovf_reg;
        if (s1_move)
        begin
            if (cmp_hit)
            begin
                diff_found_next = 1'b1;
                diff_index_next = s1_index_reg;
                diff_less_next  = a_up < b_up;
            end
            if (s1_res_reg)
            begin
                out_valid_next = 1'b1;
                out_ovf_next   = s1_ovf_reg;
                if (s1_first_sig_reg != s1_second_sig_reg)
                begin
                    out_order_next = (s1_first_sig_reg < s1_second_sig_reg)
                                     ? ORDER_LESS : ORDER_GREATER;
                end
                else if (diff_found_next && diff_index_next < s1_second_sig_reg)
                begin
                    out_order_next = diff_less_next ? ORDER_LESS : ORDER_GREATER;
                end
                else
                begin
                    out_order_next = ORDER_EQUAL;
                end
                diff_found_next = 1'b0;
                diff_index_next = '0;
                diff_less_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_found_reg <= 1'b0;
            diff_index_reg <= '0;
            diff_less_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            diff_found_reg <= diff_found_next;
            diff_index_reg <= diff_index_next;
            diff_less_reg  <= diff_less_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_order_reg <= out_order_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_ovf_reg, out_order_reg};

    // counters never pass the buffer size
    assert property (@(posedge clk) disable iff (!rst_n)
        first_count_reg <= MAX_CNT && second_count_reg <= MAX_CNT)
        else $error("pair counter beyond buffer size");

    // normalized length never exceeds the kept count
    assert property (@(posedge clk) disable iff (!rst_n)
        first_sig_reg <= first_count_reg && second_sig_reg <= second_count_reg)
        else $error("normalized length beyond kept count");

    // input stalls only when a result is blocked behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_res_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // an accepted end of the second string reaches the compare stage as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode && in_last) |=> (s1_valid_reg && s1_res_reg))
        else $error("end of pair lost before compare stage");

    // a moving result always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_res_reg) |=> (out_valid_reg && !diff_found_reg))
        else $error("result not loaded or difference not cleared");

endmodule

>>> verif/zero_trim_caseless_compare_core_tb.sv
// self-checking testbench for the zero trim caseless string comparator
`timescale 1ns / 1ps

module zero_trim_caseless_compare_core_tb;
    import zttc_pkg::*;

    localparam int BUF_DEPTH = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [2:0] PAD_ADDR = {REG_PAD_SPACE, 2'b00};

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic       ovf;
        logic [1:0] ord;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [7:0] char_byte, [8] no_byte, [15:9] zero
    logic        s_tuser;    // [0] mode
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [1:0] order, [2] overflow, [7:3] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // comparator state kept by the testbench
    logic [7:0] held_chars [BUF_DEPTH];
    int         a_count, a_len, b_count, b_len, mism_idx;
    logic       a_started, b_started, mism_found, mism_less, ovf_seen;
    logic       pad_mode;

    verdict_t   verdicts_due[$];
    int         fail_count;
    int         items_sent;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         hold_left;

    zero_trim_caseless_compare_core #(
        .MAX_LEN(BUF_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int exp, input int got);
        $display("ERROR at %0t: %s expected %0d got %0d", $realtime, what, exp, got);
        fail_count++;
    endtask

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) ? c - 8'd32 : c;
    endfunction

    function automatic logic skippable(input logic [7:0] c);
        return c == ZERO_CHAR || c == SPACE_CHAR;
    endfunction

    task automatic clear_pair_state();
        a_count = 0; a_len = 0; a_started = 1'b0;
        b_count = 0; b_len = 0; b_started = 1'b0;
        mism_found = 1'b0; mism_idx = 0; mism_less = 1'b0;
        ovf_seen = 1'b0;
    endtask

    // byte of the first string goes into the held copy
    task automatic hold_first_byte(input logic [7:0] c);
        if (!a_started)
        begin
            if (skippable(c))
                return;
            a_started = 1'b1;
        end
        if (a_count >= BUF_DEPTH)
        begin
            ovf_seen = 1'b1;
            return;
        end
        held_chars[a_count] = c;
        a_count++;
        if (!pad_mode || c != SPACE_CHAR)
            a_len = a_count;
    endtask

    // byte of the second string is compared against the held copy
    task automatic match_second_byte(input logic [7:0] c);
        logic [7:0] x, y;
        if (!b_started)
        begin
            if (skippable(c))
                return;
            b_started = 1'b1;
        end
        if (b_count >= BUF_DEPTH)
        begin
            ovf_seen = 1'b1;
            return;
        end
        if (!mism_found && b_count < a_len)
        begin
            x = fold_case(held_chars[b_count]);
            y = fold_case(c);
            if (x != y)
            begin
                mism_found = 1'b1;
                mism_idx = b_count;
                mism_less = x < y;
            end
        end
        b_count++;
        if (!pad_mode || c != SPACE_CHAR)
            b_len = b_count;
    endtask

    // one accepted item; a verdict is due when the second string ends
    task automatic predict_compare(input logic m, input logic [7:0] c, input logic nb,
                                   input logic lst);
        verdict_t v;
        if (!m)
        begin
            if (!nb)
                hold_first_byte(c);
            return;
        end
        if (!nb)
            match_second_byte(c);
        if (!lst)
            return;
        if (a_len != b_len)
            v.ord = (a_len < b_len) ? ORDER_LESS : ORDER_GREATER;
        else if (mism_found && mism_idx < b_len)
            v.ord = mism_less ? ORDER_LESS : ORDER_GREATER;
        else
            v.ord = ORDER_EQUAL;
        v.ovf = ovf_seen;
        verdicts_due.push_back(v);
        clear_pair_state();
    endtask

    task automatic check_verdict(input logic [7:0] word);
        verdict_t v;
        if (verdicts_due.size() == 0)
        begin
            report_mismatch("result with none pending, word", 0, int'(word));
            return;
        end
        v = verdicts_due.pop_front();
        if (word[1:0] !== v.ord)
            report_mismatch("order", int'(v.ord), int'(word[1:0]));
        if (word[2] !== v.ovf)
            report_mismatch("overflow", int'(v.ovf), int'(word[2]));
    endtask

    // watch both streams
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_verdict(m_tdata);
        if (rst_n && s_tvalid && s_tready)
            predict_compare(s_tuser, s_tdata[7:0], s_tdata[8], s_tlast);
    end

    // receiver with random stalls and an optional long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_item(input logic m, input logic [7:0] c, input logic nb,
                             input logic lst);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {7'd0, nb, c};
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // send one pair; the second string's final item always comes last
    task automatic send_pair(input byte_q_t a, input byte_q_t b, input bit mix_in,
                             input int noise_pct);
        int  ia, ib;
        bit  from_a;
        logic m;
        ia = 0;
        ib = 0;
        while (ia < a.size() || ib < b.size())
        begin
            if (ia == a.size())
                from_a = 1'b0;
            else if (ib == b.size() || ib == b.size() - 1)
                from_a = 1'b1;
            else
                from_a = mix_in ? 1'($urandom_range(1)) : 1'b1;
            m = !from_a;
            if ($urandom_range(99) < noise_pct)
                send_item(m, 8'($urandom_range(255)), 1'b1,
                          m ? 1'b0 : 1'($urandom_range(1)));
            if (from_a)
            begin
                send_item(1'b0, a[ia], 1'b0, 1'($urandom_range(1)));
                ia++;
            end
            else
            begin
                send_item(1'b1, b[ib], 1'b0, ib == b.size() - 1);
                ib++;
            end
        end
        if (b.size() == 0)
            send_item(1'b1, 8'($urandom_range(255)), 1'b1, 1'b1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write pad_space, then read it back
    task automatic set_pad(input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAD_ADDR;
        pwdata  <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pad_mode = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== val)
            report_mismatch("pad_space readback", int'(val), int'(prdata[0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        for (int k = 0; k < s.len(); k++)
            q.push_back(s[k]);
        return q;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'h61 + 8'($urandom_range(25));
            4, 5:       return 8'h41 + 8'($urandom_range(25));
            6:          return ZERO_CHAR + 8'($urandom_range(9));
            7:          return SPACE_CHAR;
            8:          return ZERO_CHAR;
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    // leading zeros and spaces in front, trailing spaces behind
    function automatic byte_q_t dress(input byte_q_t q);
        byte_q_t r;
        int n;
        r = q;
        n = $urandom_range(3);
        repeat (n) r.push_front($urandom_range(1) ? ZERO_CHAR : SPACE_CHAR);
        n = $urandom_range(2);
        repeat (n) r.push_back(SPACE_CHAR);
        return r;
    endfunction

    // extremes of the fields, case folding, length and byte order
    task automatic test_directed();
        byte_q_t lo, hi;
        lo = '{8'h00};
        hi = '{8'hFF};
        send_item(1'b0, 8'h5A, 1'b1, 1'b1);
        send_item(1'b1, 8'h5A, 1'b1, 1'b1);
        send_pair(to_bytes("0 012"), to_bytes("12"), 1'b0, 0);
        send_pair(lo, hi, 1'b0, 0);
        send_pair(to_bytes("abd"), to_bytes("ABC"), 1'b0, 0);
        // no-byte item in the middle of the second string
        send_item(1'b0, "a", 1'b0, 1'b0);
        send_item(1'b0, "b", 1'b0, 1'b1);
        send_item(1'b1, "a", 1'b0, 1'b0);
        send_item(1'b1, 8'hA5, 1'b1, 1'b0);
        send_item(1'b1, "B", 1'b0, 1'b0);
        send_item(1'b1, "c", 1'b0, 1'b1);
        wait_idle();
    endtask

    // trailing space handling, including a change within a pair
    task automatic test_pad_mode();
        set_pad(1'b1);
        send_pair(to_bytes("ab  "), to_bytes(" 0AB"), 1'b0, 0);
        wait_idle();
        set_pad(1'b0);
        send_pair(to_bytes("ab  "), to_bytes("ab"), 1'b0, 0);
        send_item(1'b0, "x", 1'b0, 1'b0);
        send_item(1'b0, "y", 1'b0, 1'b0);
        send_item(1'b0, SPACE_CHAR, 1'b0, 1'b0);
        wait_idle();
        set_pad(1'b1);
        send_pair(to_bytes("  "), to_bytes("xy "), 1'b0, 0);
        wait_idle();
    endtask

    // both strings one byte past the buffer size
    task automatic test_overflow();
        byte_q_t a, b;
        a = '{8'h41};
        repeat (BUF_DEPTH) a.push_back(pick_char());
        b = a;
        send_pair(a, b, 1'b0, 2);
        wait_idle();
        set_pad(1'($urandom_range(1)));
    endtask

    // receiver holds off while short pairs keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        hold_left = 150;
        repeat (20)
            send_pair(to_bytes("1"), to_bytes($urandom_range(1) ? "2" : "1"), 1'b0, 0);
        wait_idle();
        tx_idle_pct = 18;
    endtask

    // random pairs: mostly near-equal strings, some interleaved, some noise
    task automatic test_random();
        byte_q_t core, a, b;
        int start, len, pick;
        start = items_sent;
        while (items_sent - start < 120)
        begin
            // quiet stretch with no idling on either side
            if (items_sent - start >= 30 && items_sent - start < 90)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 18;
                rx_idle_pct = 18;
            end
            core.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
            repeat (len) core.push_back(pick_char());
            b = core;
            foreach (b[k])
                if ((b[k] | 8'h20) >= LOWER_A && (b[k] | 8'h20) <= LOWER_Z
                    && $urandom_range(1))
                    b[k] = b[k] ^ 8'h20;
            pick = $urandom_range(9);
            if (pick < 3 && b.size() > 0)
                b[$urandom_range(b.size() - 1)] = pick_char();
            else if (pick == 3)
                b.push_back(pick_char());
            else if (pick == 4 && b.size() > 0)
                void'(b.pop_back());
            a = dress(core);
            b = dress(b);
            pick = $urandom_range(19);
            if (pick < 17)
            begin
                send_pair(a, b, 1'b0, 5);
            end
            else if (pick < 19)
            begin
                send_pair(a, b, 1'b1, 5);
            end
            else
            begin
                // broken sequence of random items
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(1))
                        send_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                    else
                        send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'b0);
                end
                send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
            if ($urandom_range(5) == 0)
            begin
                wait_idle();
                set_pad(1'($urandom_range(1)));
            end
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'd0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        pad_mode = 1'b0;
        fail_count  = 0;
        items_sent  = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 18;
        hold_left   = 0;
        clear_pair_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pad_mode();
        test_overflow();
        test_backpressure();
        test_random();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
